// File: rtl/akhc_pkg.sv
// Package: link state codes, protocol byte constants, item and result types.
`default_nettype none
package akhc_pkg;

    typedef enum logic [2:0] {
        LS_UNINIT    = 3'd0,
        LS_WAIT_ACK  = 3'd1,
        LS_WAIT_TEST = 3'd2,
        LS_SET_LEDS  = 3'd3,
        LS_READY     = 3'd4
    } t_link_state;

    localparam logic       KIND_FRAME = 1'b0;
    localparam logic       KIND_TICK  = 1'b1;

    localparam logic [7:0] BYTE_SELF_TEST_OK = 8'hAA;
    localparam logic [7:0] BYTE_ACK          = 8'hFA;
    localparam logic [7:0] BYTE_RESET        = 8'hFF;
    localparam logic [7:0] BYTE_RESEND       = 8'hFE;
    localparam logic [7:0] BYTE_SET_LEDS     = 8'hED;
    localparam logic [7:0] BYTE_SHIFTED_AA   = 8'h54;

    localparam logic [1:0] SOUND_NONE  = 2'd0;
    localparam logic [1:0] SOUND_READY = 2'd1;
    localparam logic [1:0] SOUND_LEDS  = 2'd2;

    localparam logic [1:0] FERR_NONE    = 2'd0;
    localparam logic [1:0] FERR_PARITY  = 2'd1;
    localparam logic [1:0] FERR_FRAMING = 2'd2;

    localparam logic       CFG_DETECT_INTERVAL = 1'b0;
    localparam logic       CFG_DETECT_RETRIES  = 1'b1;

    localparam logic [15:0] DETECT_INTERVAL_RST = 16'd1000;
    localparam logic [3:0]  DETECT_RETRIES_RST  = 4'd3;
    localparam logic [15:0] ELAPSED_MAX         = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [10:0] frame_bits;
        logic        clock_line_high;
        logic [2:0]  lock_values;
    } t_item;

    typedef struct packed {
        t_link_state link;
        logic [2:0]  sent_leds;
        logic [15:0] elapsed_ms;
        logic [3:0]  presence_count;
    } t_state;

    typedef struct packed {
        logic       command_valid;
        logic [8:0] command_frame;
        logic       scancode_valid;
        logic [7:0] scancode;
        logic       restart_receiver;
        logic [1:0] sound;
        logic [1:0] frame_error;
    } t_result;

    function automatic logic odd_parity(input logic [7:0] b);
        odd_parity = ~(^b);
    endfunction

endpackage
`default_nettype wire

// File: rtl/akhc_step.sv
// Single-pass link logic: next link state and result for one beat.
`default_nettype none
module akhc_step (
    input  var akhc_pkg::t_item   i_item,
    input  var akhc_pkg::t_state  i_state,
    input  wire logic [15:0]      i_detect_interval,
    input  wire logic [3:0]       i_detect_retries,
    output akhc_pkg::t_state      o_state,
    output akhc_pkg::t_result     o_result
);
    import akhc_pkg::*;

    logic [7:0]  data;
    logic        par;
    logic        par_bad;
    logic        framing_bad;
    logic        shifted_aa;
    logic        leds_differ;
    logic        not_ready_side;
    logic        poll;
    logic [15:0] elapsed_inc;
    t_link_state eff_link;
    logic        cmd_valid;
    logic [7:0]  cmd_byte;

    assign data           = i_item.frame_bits[8:1];
    assign par            = i_item.frame_bits[9];
    assign par_bad        = (par != odd_parity(data));
    assign framing_bad    = i_item.frame_bits[0] | ~i_item.frame_bits[10];
    assign shifted_aa     = (data == BYTE_SHIFTED_AA) && par;
    assign leds_differ    = (i_item.lock_values != i_state.sent_leds);
    assign eff_link       = framing_bad ? LS_UNINIT : i_state.link;
    assign not_ready_side = (i_state.link != LS_SET_LEDS) && (i_state.link != LS_READY);
    assign elapsed_inc    = (i_state.elapsed_ms == ELAPSED_MAX) ? ELAPSED_MAX
                                                                : i_state.elapsed_ms + 16'd1;
    assign poll           = not_ready_side && (elapsed_inc > i_detect_interval);

    // next state
    always_comb begin
        o_state = i_state;
        if (i_item.kind == KIND_FRAME) begin
            if (par_bad) begin
                if (shifted_aa) begin
                    o_state.link = LS_UNINIT;
                end
            end else begin
                case (eff_link)
                    LS_WAIT_ACK: begin
                        if (data == BYTE_ACK) begin
                            o_state.link = LS_WAIT_TEST;
                        end
                    end
                    LS_WAIT_TEST: begin
                        if (data == BYTE_SELF_TEST_OK) begin
                            o_state.link      = LS_READY;
                            o_state.sent_leds = 3'd0;
                        end else begin
                            o_state.link = LS_WAIT_ACK;
                        end
                    end
                    LS_SET_LEDS: begin
                        if (data == BYTE_ACK) begin
                            if (leds_differ) begin
                                o_state.sent_leds = i_item.lock_values;
                            end else begin
                                o_state.link = LS_READY;
                            end
                        end else begin
                            o_state.sent_leds = i_item.lock_values;
                            o_state.link      = LS_READY;
                        end
                    end
                    LS_READY: begin
                        o_state.link = LS_READY;
                    end
                    default: begin
                        if (data == BYTE_SELF_TEST_OK) begin
                            o_state.link      = LS_READY;
                            o_state.sent_leds = 3'd0;
                        end else begin
                            o_state.link = LS_WAIT_ACK;
                        end
                    end
                endcase
            end
        end else begin
            o_state.elapsed_ms = elapsed_inc;
            if (not_ready_side) begin
                if (poll) begin
                    o_state.elapsed_ms = 16'd0;
                    if (i_item.clock_line_high) begin
                        if (i_state.presence_count < i_detect_retries) begin
                            o_state.presence_count = i_state.presence_count + 4'd1;
                        end else begin
                            o_state.link           = LS_WAIT_ACK;
                            o_state.presence_count = 4'd0;
                        end
                    end
                end
            end else if (i_state.link == LS_READY && leds_differ) begin
                o_state.link = LS_SET_LEDS;
            end
        end
    end

    // result
    always_comb begin
        cmd_valid                 = 1'b0;
        cmd_byte                  = 8'd0;
        o_result.scancode_valid   = 1'b0;
        o_result.scancode         = 8'd0;
        o_result.restart_receiver = 1'b0;
        o_result.sound            = SOUND_NONE;
        o_result.frame_error      = FERR_NONE;
        if (i_item.kind == KIND_FRAME) begin
            if (par_bad) begin
                o_result.frame_error      = FERR_PARITY;
                o_result.restart_receiver = shifted_aa;
                cmd_valid                 = 1'b1;
                cmd_byte                  = BYTE_RESEND;
            end else begin
                if (framing_bad) begin
                    o_result.frame_error      = FERR_FRAMING;
                    o_result.restart_receiver = 1'b1;
                end
                case (eff_link)
                    LS_WAIT_ACK: begin
                        if (data != BYTE_ACK) begin
                            cmd_valid = 1'b1;
                            cmd_byte  = BYTE_RESET;
                        end
                    end
                    LS_SET_LEDS: begin
                        if (data == BYTE_ACK) begin
                            if (leds_differ) begin
                                cmd_valid = 1'b1;
                                cmd_byte  = {5'd0, i_item.lock_values};
                            end else begin
                                o_result.sound = SOUND_LEDS;
                            end
                        end
                    end
                    LS_READY: begin
                        o_result.scancode_valid = 1'b1;
                        o_result.scancode       = data;
                    end
                    default: begin
                        if (data == BYTE_SELF_TEST_OK) begin
                            o_result.sound = SOUND_READY;
                        end else begin
                            cmd_valid = 1'b1;
                            cmd_byte  = BYTE_RESET;
                        end
                    end
                endcase
            end
        end else begin
            if (poll && i_item.clock_line_high
                    && !(i_state.presence_count < i_detect_retries)) begin
                cmd_valid = 1'b1;
                cmd_byte  = BYTE_RESET;
            end else if (i_state.link == LS_READY && leds_differ) begin
                cmd_valid = 1'b1;
                cmd_byte  = BYTE_SET_LEDS;
            end
        end
        o_result.command_valid = cmd_valid;
        o_result.command_frame = cmd_valid ? {odd_parity(cmd_byte), cmd_byte} : 9'd0;
    end

endmodule
`default_nettype wire

// File: rtl/at_keyboard_host_controller_unit.sv
// Top level of the AT keyboard host controller: beat registers, link state, config.
//
// Input channel (i_in_valid / o_in_ready) carries one beat: either a received
// 11-bit frame (i_kind = 0) or a one-millisecond tick (i_kind = 1), with the
// clock line level and the requested lock LEDs. Output channel (o_out_valid /
// i_out_ready) returns exactly one result beat per input beat, in order.
// The input register is loaded when a beat is accepted and the result register
// when that beat advances, which waits while the receiver stalls.
// Throughput is one beat per cycle while the receiver takes results; the link
// state and counters update as a beat leaves the input register.
// When the receiver stalls, the result register holds and one more beat can
// still wait in the input register; o_in_ready drops only when both are full.
// The config port (i_cfg_we, i_cfg_idx, i_cfg_wdata) writes the presence poll
// interval (index 0) and the retry count (index 1), with no wait state.
// Synchronous active-low reset clears both beat registers, the link state to
// uninitialized, the sent LEDs, elapsed time and presence count, and restores
// the poll interval to 1000 ms and the retry count to 3.
`default_nettype none
module at_keyboard_host_controller_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [10:0] i_frame_bits,
    input  wire logic        i_clock_line_high,
    input  wire logic [2:0]  i_lock_values,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_command_valid,
    output logic [8:0]       o_command_frame,
    output logic             o_scancode_valid,
    output logic [7:0]       o_scancode,
    output logic             o_restart_receiver,
    output logic [1:0]       o_sound,
    output logic [1:0]       o_frame_error,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_wdata
);
    import akhc_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_result     r_out;
    t_state      r_state;
    logic [15:0] r_detect_interval;
    logic [3:0]  r_detect_retries;

    t_state      n_state;
    t_result     n_result;
    t_item       in_item;
    logic        out_free;
    logic        advance;

    assign in_item.kind            = i_kind;
    assign in_item.frame_bits      = i_frame_bits;
    assign in_item.clock_line_high = i_clock_line_high;
    assign in_item.lock_values     = i_lock_values;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    akhc_step u_step (
        .i_item            (r_in),
        .i_state           (r_state),
        .i_detect_interval (r_detect_interval),
        .i_detect_retries  (r_detect_retries),
        .o_state           (n_state),
        .o_result          (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.link           <= LS_UNINIT;
            r_state.sent_leds      <= 3'd0;
            r_state.elapsed_ms     <= 16'd0;
            r_state.presence_count <= 4'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_interval <= DETECT_INTERVAL_RST;
            r_detect_retries  <= DETECT_RETRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DETECT_INTERVAL: r_detect_interval <= i_cfg_wdata;
                CFG_DETECT_RETRIES:  r_detect_retries  <= i_cfg_wdata[3:0];
                default:             r_detect_retries  <= r_detect_retries;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_command_valid    = r_out.command_valid;
    assign o_command_frame    = r_out.command_frame;
    assign o_scancode_valid   = r_out.scancode_valid;
    assign o_scancode         = r_out.scancode;
    assign o_restart_receiver = r_out.restart_receiver;
    assign o_sound            = r_out.sound;
    assign o_frame_error      = r_out.frame_error;

    a_cmd_sc_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_command_valid && o_scancode_valid))
        else $error("command and scancode in one beat");

    a_sc_clean_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scancode_valid) |-> (o_frame_error == FERR_NONE))
        else $error("scancode forwarded from bad frame");

    a_cmd_odd_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_command_valid) |-> (^o_command_frame))
        else $error("command frame without odd parity");

    a_ready_cue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_result.sound == SOUND_READY) |=> (r_state.link == LS_READY))
        else $error("ready cue without ready link state");

endmodule
`default_nettype wire

// File: bench/tb_at_keyboard_host_controller_unit.sv
// Self-checking testbench for the AT keyboard host controller: link predictor and random traffic.
`default_nettype none
module tb_at_keyboard_host_controller_unit;
    import akhc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_kind = 1'b0;
    logic [10:0] i_frame_bits = '0;
    logic        i_clock_line_high = 1'b0;
    logic [2:0]  i_lock_values = '0;
    logic        i_out_ready = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_command_valid;
    logic [8:0]  o_command_frame;
    logic        o_scancode_valid;
    logic [7:0]  o_scancode;
    logic        o_restart_receiver;
    logic [1:0]  o_sound;
    logic [1:0]  o_frame_error;

    at_keyboard_host_controller_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_frame_bits       (i_frame_bits),
        .i_clock_line_high  (i_clock_line_high),
        .i_lock_values      (i_lock_values),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_command_valid    (o_command_valid),
        .o_command_frame    (o_command_frame),
        .o_scancode_valid   (o_scancode_valid),
        .o_scancode         (o_scancode),
        .o_restart_receiver (o_restart_receiver),
        .o_sound            (o_sound),
        .o_frame_error      (o_frame_error),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    t_link_state pred_link = LS_UNINIT;
    logic [2:0]  pred_leds = '0;
    logic [15:0] pred_elapsed = '0;
    logic [3:0]  pred_presence = '0;
    logic [15:0] pred_interval = DETECT_INTERVAL_RST;
    logic [3:0]  pred_retries = DETECT_RETRIES_RST;
    logic [2:0]  want_locks = '0;

    t_result expected_link_results[$];
    int  mismatch_count = 0;
    int  out_beats = 0;
    int  stuck_cycles = 0;
    int  hold_off_req = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  traffic_gaps = 1'b1;

    function automatic logic [8:0] cmd_word(input logic [7:0] b);
        return {~(^b), b};
    endfunction

    function automatic t_result predict_link(input t_item it);
        t_result r;
        logic [7:0] d;
        r = '0;
        d = it.frame_bits[8:1];
        if (it.kind == KIND_TICK) begin
            if (pred_elapsed != ELAPSED_MAX) pred_elapsed = pred_elapsed + 16'd1;
            if (pred_link == LS_READY) begin
                if (it.lock_values != pred_leds) begin
                    pred_link = LS_SET_LEDS;
                    r.command_valid = 1'b1;
                    r.command_frame = cmd_word(BYTE_SET_LEDS);
                end
            end else if (pred_link != LS_SET_LEDS && pred_elapsed > pred_interval) begin
                pred_elapsed = '0;
                if (it.clock_line_high) begin
                    if (pred_presence < pred_retries) begin
                        pred_presence = pred_presence + 4'd1;
                    end else begin
                        pred_link = LS_WAIT_ACK;
                        pred_presence = '0;
                        r.command_valid = 1'b1;
                        r.command_frame = cmd_word(BYTE_RESET);
                    end
                end
            end
            return r;
        end
        if (it.frame_bits[9] != ~(^d)) begin
            r.frame_error = FERR_PARITY;
            if (d == BYTE_SHIFTED_AA && it.frame_bits[9]) begin
                r.restart_receiver = 1'b1;
                pred_link = LS_UNINIT;
            end
            r.command_valid = 1'b1;
            r.command_frame = cmd_word(BYTE_RESEND);
            return r;
        end
        if (it.frame_bits[0] || !it.frame_bits[10]) begin
            r.frame_error = FERR_FRAMING;
            r.restart_receiver = 1'b1;
            pred_link = LS_UNINIT;
        end
        case (pred_link)
            LS_WAIT_ACK: begin
                if (d == BYTE_ACK) begin
                    pred_link = LS_WAIT_TEST;
                end else begin
                    r.command_valid = 1'b1;
                    r.command_frame = cmd_word(BYTE_RESET);
                end
            end
            LS_SET_LEDS: begin
                if (d == BYTE_ACK) begin
                    if (it.lock_values != pred_leds) begin
                        pred_leds = it.lock_values;
                        r.command_valid = 1'b1;
                        r.command_frame = cmd_word({5'd0, it.lock_values});
                    end else begin
                        r.sound = SOUND_LEDS;
                        pred_link = LS_READY;
                    end
                end else begin
                    pred_leds = it.lock_values;
                    pred_link = LS_READY;
                end
            end
            LS_READY: begin
                r.scancode_valid = 1'b1;
                r.scancode = d;
            end
            default: begin
                if (d == BYTE_SELF_TEST_OK) begin
                    r.sound = SOUND_READY;
                    pred_leds = '0;
                    pred_link = LS_READY;
                end else begin
                    pred_link = LS_WAIT_ACK;
                    r.command_valid = 1'b1;
                    r.command_frame = cmd_word(BYTE_RESET);
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_item frame_item(input logic [7:0] d, input logic par_flip,
                                         input logic start_b, input logic stop_b,
                                         input logic [2:0] locks);
        t_item it;
        it.kind = KIND_FRAME;
        it.frame_bits = {stop_b, ~(^d) ^ par_flip, d, start_b};
        it.clock_line_high = 1'($urandom_range(0, 1));
        it.lock_values = locks;
        return it;
    endfunction

    function automatic t_item tick_item(input logic clk_high, input logic [2:0] locks);
        t_item it;
        it.kind = KIND_TICK;
        it.frame_bits = 11'($urandom_range(0, 2047));
        it.clock_line_high = clk_high;
        it.lock_values = locks;
        return it;
    endfunction

    // Mostly well-formed handshake traffic, steered by the predicted link state.
    function automatic t_item rand_link_item();
        t_item it;
        logic [7:0] d;
        int pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) want_locks = 3'($urandom_range(0, 7));
        if (pick < 30) return tick_item($urandom_range(0, 7) != 0, want_locks);
        d = 8'($urandom_range(0, 255));
        case (pred_link)
            LS_WAIT_ACK, LS_SET_LEDS: if ($urandom_range(0, 3) != 0) d = BYTE_ACK;
            LS_READY: if ($urandom_range(0, 15) == 0) d = BYTE_SELF_TEST_OK;
            default: if ($urandom_range(0, 3) != 0) d = BYTE_SELF_TEST_OK;
        endcase
        if (pick < 86) return frame_item(d, 1'b0, 1'b0, 1'b1, want_locks);
        if (pick < 89) return frame_item(BYTE_SHIFTED_AA, 1'b1, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), want_locks);
        if (pick < 93) return frame_item(d, 1'b1, 1'($urandom_range(0, 1)),
                                         1'($urandom_range(0, 1)), want_locks);
        if (pick < 97) return frame_item(d, 1'b0, pick != 94, pick == 93, want_locks);
        it = tick_item(1'b0, want_locks);
        it.kind = KIND_FRAME;
        return it;
    endfunction

    task automatic send_beat(input t_item it);
        if (traffic_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= it.kind;
        i_frame_bits      <= it.frame_bits;
        i_clock_line_high <= it.clock_line_high;
        i_lock_values     <= it.lock_values;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_link_results.push_back(predict_link(it));
    endtask

    task automatic settle_link();
        i_in_valid <= 1'b0;
        while (expected_link_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_link(input logic [15:0] interval, input logic [3:0] retries);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_DETECT_INTERVAL;
        i_cfg_wdata <= interval;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_DETECT_RETRIES;
        i_cfg_wdata <= {12'd0, retries};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pred_interval = interval;
        pred_retries  = retries;
    endtask

    // Reset values: no poll under the reset interval, then the reset retry count
    // lets the fourth poll force a reset command.
    task automatic test_default_poll();
        repeat (20) send_beat(tick_item(1'b1, 3'd0));
        settle_link();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_DETECT_INTERVAL;
        i_cfg_wdata <= 16'd2;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        pred_interval = 16'd2;
        repeat (16) send_beat(tick_item(1'b1, 3'd0));
        settle_link();
    endtask

    task automatic test_link_bringup();
        send_beat(frame_item(8'h12, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(frame_item(BYTE_ACK, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(frame_item(8'h00, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(frame_item(BYTE_ACK, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(frame_item(BYTE_SELF_TEST_OK, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(frame_item(8'h00, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(frame_item(8'hFF, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(tick_item(1'b1, 3'd7));
        send_beat(frame_item(BYTE_ACK, 1'b0, 1'b0, 1'b1, 3'd7));
        send_beat(frame_item(BYTE_ACK, 1'b0, 1'b0, 1'b1, 3'd7));
        send_beat(tick_item(1'b0, 3'd0));
        send_beat(frame_item(8'h12, 1'b0, 1'b0, 1'b1, 3'd0));
        send_beat(tick_item(1'b1, 3'd0));
        send_beat(frame_item(8'h00, 1'b1, 1'b0, 1'b0, 3'd0));
        send_beat(frame_item(BYTE_SHIFTED_AA, 1'b1, 1'b1, 1'b0, 3'd0));
        send_beat(frame_item(8'hFF, 1'b0, 1'b1, 1'b1, 3'd0));
        send_beat(frame_item(BYTE_SELF_TEST_OK, 1'b0, 1'b0, 1'b0, 3'd0));
        send_beat(frame_item(BYTE_SHIFTED_AA, 1'b0, 1'b0, 1'b1, 3'd0));
        settle_link();
    endtask

    task automatic test_presence_poll();
        send_beat(frame_item(BYTE_SHIFTED_AA, 1'b1, 1'b0, 1'b1, 3'd0));
        settle_link();
        program_link(16'd1, 4'd0);
        repeat (6) send_beat(tick_item(1'b0, 3'd5));
        repeat (4) send_beat(tick_item(1'b1, 3'd2));
        settle_link();
        program_link(16'd1, 4'd15);
        repeat (40) send_beat(tick_item(1'b1, 3'd0));
        settle_link();
    endtask

    // Interval at its maximum holds off polling; the count carries over once it is lowered.
    task automatic test_long_interval();
        send_beat(frame_item(BYTE_SHIFTED_AA, 1'b1, 1'b0, 1'b1, 3'd0));
        settle_link();
        program_link(16'hFFFF, 4'd3);
        traffic_gaps = 1'b0;
        repeat (100) send_beat(tick_item(1'b1, 3'd0));
        settle_link();
        program_link(16'd50, 4'd0);
        traffic_gaps = 1'b1;
        repeat (3) send_beat(tick_item(1'b1, 3'd0));
        settle_link();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++) begin
            settle_link();
            case (ph)
                0: program_link(16'd1, 4'd0);
                1: program_link(16'd7, 4'd2);
                2: program_link(16'd40, 4'd15);
                default: program_link(16'($urandom_range(1, 40)), 4'($urandom_range(0, 15)));
            endcase
            repeat (230) send_beat(rand_link_item());
        end
        settle_link();
    endtask

    task automatic test_backpressure();
        traffic_gaps = 1'b0;
        program_link(16'd5, 4'd1);
        hold_off_req = HOLD_OFF_CYCLES;
        repeat (60) send_beat(rand_link_item());
        settle_link();
        traffic_gaps = 1'b1;
    endtask

    task automatic test_steady_stream();
        traffic_gaps = 1'b0;
        program_link(16'($urandom_range(1, 20)), 4'($urandom_range(0, 15)));
        repeat (200) send_beat(rand_link_item());
    endtask

    always @(posedge i_clk) begin : drain_results
        t_result act;
        t_result exp_r;
        if (o_out_valid && i_out_ready) begin
            act.command_valid    = o_command_valid;
            act.command_frame    = o_command_frame;
            act.scancode_valid   = o_scancode_valid;
            act.scancode         = o_scancode;
            act.restart_receiver = o_restart_receiver;
            act.sound            = o_sound;
            act.frame_error      = o_frame_error;
            out_beats++;
            if (expected_link_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("beat %0d: result with none expected", out_beats);
            end else begin
                exp_r = expected_link_results.pop_front();
                if (act.command_valid !== exp_r.command_valid
                        || act.command_frame !== exp_r.command_frame
                        || act.scancode_valid !== exp_r.scancode_valid
                        || act.scancode !== exp_r.scancode
                        || act.restart_receiver !== exp_r.restart_receiver
                        || act.sound !== exp_r.sound
                        || act.frame_error !== exp_r.frame_error) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat %0d: exp cmd %b/%h sc %b/%h rst %b snd %0d ferr %0d",
                                 out_beats, exp_r.command_valid, exp_r.command_frame,
                                 exp_r.scancode_valid, exp_r.scancode,
                                 exp_r.restart_receiver, exp_r.sound, exp_r.frame_error,
                                 "\n          got cmd %b/%h sc %b/%h rst %b snd %0d ferr %0d",
                                 act.command_valid, act.command_frame,
                                 act.scancode_valid, act.scancode,
                                 act.restart_receiver, act.sound, act.frame_error);
                end
            end
        end
        if (hold_off_req > 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (traffic_gaps && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_poll();
        test_link_bringup();
        test_presence_poll();
        test_long_interval();
        test_random_traffic();
        test_backpressure();
        test_steady_stream();
        settle_link();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_link_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
`default_nettype wire
